// ----- rtl/csa_pkg.sv -----
// Package with the shared types and codes of the context slot allocator.
`default_nettype none
package csa_pkg;

  localparam int KEY_W   = 5;
  localparam int DATA_W  = 64;
  localparam int KEY_LIMIT = 31;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_BADKEY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/csa_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire  logic                 clk,
  input  wire  logic                 we,
  input  wire  logic [ADDR_W-1:0]    waddr,
  input  wire  logic [WIDTH-1:0]     wdata,
  input  wire  logic                 re,
  input  wire  logic [ADDR_W-1:0]    raddr,
  output       logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csa_free_enc.sv -----
// Priority encoder that finds the lowest-numbered free slot that can be keyed.
`default_nettype none
module csa_free_enc
  import csa_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire  logic [SLOT_COUNT-1:0] busy,
  output       logic                  found,
  output       logic [IDX_W-1:0]      idx
);

  localparam int USABLE = (SLOT_COUNT < KEY_LIMIT) ? SLOT_COUNT : KEY_LIMIT;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/context_slot_allocator.sv -----
// Top level of the context slot allocator: busy bits, slot RAM and control.
// An allocate request and a rejected release give their result in the cycle after acceptance.
// A valid release reads the slot RAM through its registered read port in state ST_READ, then registers its result.
// Throughput is one allocate per cycle while the output is not stalled; a valid release holds off
// new requests while it waits in ST_READ on the registered read port of the slot RAM.
// Synchronous reset marks every slot free at once; the slot RAM itself is not cleared.
`default_nettype none
module context_slot_allocator
  import csa_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              in_valid,
  output       logic              in_stall,
  input  wire  logic              opcode,
  input  wire  logic [DATA_W-1:0] handle_in,
  input  wire  logic [DATA_W-1:0] offset_in,
  input  wire  logic [DATA_W-1:0] tag_in,
  input  wire  logic [KEY_W-1:0]  release_key,
  output       logic              out_valid,
  input  wire  logic              out_stall,
  output       logic [KEY_W-1:0]  key_out,
  output       logic [DATA_W-1:0] handle_out,
  output       logic [DATA_W-1:0] offset_out,
  output       logic [DATA_W-1:0] tag_out,
  output       logic [1:0]        status
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int USABLE = (SLOT_COUNT < KEY_LIMIT) ? SLOT_COUNT : KEY_LIMIT;
  localparam int WIDE_W = (IDX_W > KEY_W) ? IDX_W : KEY_W;
  localparam int ROW_W  = 3 * DATA_W;
  localparam logic [SLOT_COUNT-1:0] USABLE_MASK =
    {SLOT_COUNT{1'b1}} >> (SLOT_COUNT - USABLE);

  state_t state, state_next;

  logic [SLOT_COUNT-1:0] busy, busy_next;
  logic [IDX_W-1:0]      pend_idx, pend_idx_next;
  logic                  res_valid, res_valid_next;
  logic [KEY_W-1:0]      res_key, res_key_next;
  logic [DATA_W-1:0]     res_handle, res_handle_next;
  logic [DATA_W-1:0]     res_offset, res_offset_next;
  logic [DATA_W-1:0]     res_tag, res_tag_next;
  logic [1:0]            res_status, res_status_next;

  logic                  accept;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [KEY_W-1:0]      key_m1;
  logic [WIDE_W-1:0]     key_wide;
  logic [IDX_W-1:0]      rel_idx;
  logic                  key_ok;

  logic                  ram_we;
  logic                  ram_re;
  logic [ROW_W-1:0]      ram_rdata;

  csa_free_enc #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_free_enc (
    .busy (busy),
    .found(free_found),
    .idx  (free_idx)
  );

  csa_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata({handle_in, offset_in, tag_in}),
    .re   (ram_re),
    .raddr(rel_idx),
    .rdata(ram_rdata)
  );

  assign key_m1   = release_key - KEY_W'(1);
  assign key_wide = WIDE_W'(key_m1);
  assign rel_idx  = key_wide[IDX_W-1:0];

  always_comb begin
    key_ok = 1'b0;
    if ((release_key != '0) && ({1'b0, release_key} <= (KEY_W + 1)'(USABLE))) begin
      key_ok = busy[rel_idx];
    end
  end

  assign in_stall  = (state != ST_IDLE) || (res_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = res_valid;
  assign key_out   = res_key;
  assign handle_out = res_handle;
  assign offset_out = res_offset;
  assign tag_out   = res_tag;
  assign status    = res_status;

  always_comb begin
    state_next      = state;
    busy_next       = busy;
    pend_idx_next   = pend_idx;
    res_valid_next  = res_valid && out_stall;
    res_key_next    = res_key;
    res_handle_next = res_handle;
    res_offset_next = res_offset;
    res_tag_next    = res_tag;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_handle_next = '0;
          res_offset_next = '0;
          res_tag_next    = '0;
          res_key_next    = '0;
          if (opcode == OP_ALLOC) begin
            res_valid_next = 1'b1;
            if (free_found) begin
              busy_next[free_idx] = 1'b1;
              ram_we              = 1'b1;
              res_key_next        = KEY_W'(free_idx) + KEY_W'(1);
              res_status_next     = STATUS_OK;
            end else begin
              res_status_next = STATUS_FULL;
            end
          end else if (key_ok) begin
            ram_re        = 1'b1;
            pend_idx_next = rel_idx;
            state_next    = ST_READ;
          end else begin
            res_valid_next  = 1'b1;
            res_status_next = STATUS_BADKEY;
          end
        end
      end
      ST_READ: begin
        res_valid_next      = 1'b1;
        res_key_next        = '0;
        res_handle_next     = ram_rdata[3*DATA_W-1:2*DATA_W];
        res_offset_next     = ram_rdata[2*DATA_W-1:DATA_W];
        res_tag_next        = ram_rdata[DATA_W-1:0];
        res_status_next     = STATUS_OK;
        busy_next[pend_idx] = 1'b0;
        state_next          = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      busy      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx   <= pend_idx_next;
    res_key    <= res_key_next;
    res_handle <= res_handle_next;
    res_offset <= res_offset_next;
    res_tag    <= res_tag_next;
    res_status <= res_status_next;
  end

  a_read_output_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !res_valid)
    else $error("Output register occupied while a slot read is pending.");

  a_read_slot_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> busy[pend_idx])
    else $error("Pending release refers to a free slot.");

  a_alloc_marks_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_ALLOC) && free_found) |=> busy[$past(free_idx)])
    else $error("Allocated slot is not marked busy.");

  a_unkeyable_free: assert property (@(posedge clk) disable iff (rst)
    (busy & ~USABLE_MASK) == '0)
    else $error("A slot beyond the keyable range became busy.");

endmodule
`default_nettype wire
